### rtl/gbs_pkg.sv
package gbs_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 11;
    localparam int WID_W      = 12;
    localparam int HGT_W      = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int MAX_HEIGHT = 4096;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Window columns: [0..2] oldest column (top, mid, bottom), [3..5] previous column
    typedef logic [5:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] blurred;
        logic [PIX_W-1:0] sharpened;
        logic             last;
    } t_result;

endpackage

### rtl/gbs_line_store.sv
module gbs_line_store
    import gbs_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    output logic [PIX_W-1:0]             o_rd_top,
    output logic [PIX_W-1:0]             o_rd_mid,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  logic [PIX_W-1:0]             i_wr_top,
    input  logic [PIX_W-1:0]             i_wr_mid
);

    // Both line stores share one address, so keep them side by side in one word.
    logic [2*PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_top, i_wr_mid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_top = r_rd_data[2*PIX_W-1:PIX_W];
    assign o_rd_mid = r_rd_data[PIX_W-1:0];

endmodule

### rtl/gbs_kernel.sv
module gbs_kernel
    import gbs_pkg::*;
(
    input  t_win             i_win,
    input  logic [PIX_W-1:0] i_top,
    input  logic [PIX_W-1:0] i_mid,
    input  logic [PIX_W-1:0] i_px,
    output logic [PIX_W-1:0] o_blurred,
    output logic [PIX_W-1:0] o_sharpened
);

    logic [11:0]        gsum;
    logic [10:0]        spos;
    logic [9:0]         sneg;
    logic signed [11:0] sdiff;
    logic               in_range;

    always_comb begin
        gsum = 12'(i_win[0]) + 12'(i_win[2]) + 12'(i_top) + 12'(i_px)
             + ((12'(i_win[3]) + 12'(i_win[1]) + 12'(i_mid) + 12'(i_win[5])) << 1)
             + (12'(i_win[4]) << 2);
        spos = (11'(i_win[4]) << 2) + 11'(i_win[4]);
        sneg = 10'(i_win[3]) + 10'(i_win[5]) + 10'(i_win[1]) + 10'(i_mid);
        sdiff = $signed(12'(spos)) - $signed(12'(sneg));
        in_range = (sdiff >= 12'sd1) && (sdiff <= 12'sd254);
        o_blurred = gsum[11:4];
        o_sharpened = in_range ? sdiff[PIX_W-1:0] : i_win[4];
    end

endmodule

### rtl/gbs_out_fifo.sv
module gbs_out_fifo
    import gbs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push_a,
    input  t_result            i_data_a,
    input  logic               i_push_b,
    input  t_result            i_data_b,
    input  logic               i_pop,
    output logic               o_valid,
    output t_result            o_data,
    output logic [FIFO_CW-1:0] o_count
);

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;
    logic [FIFO_AW-1:0] n_wr_ptr;
    logic [FIFO_CW-1:0] n_count;
    logic [1:0]         push_cnt;
    logic               pop_ok;

    always_comb begin
        push_cnt = 2'(i_push_a) + 2'(i_push_b);
        pop_ok = i_pop && (r_count != '0);
        n_wr_ptr = r_wr_ptr + FIFO_AW'(push_cnt);
        n_count = r_count + FIFO_CW'(push_cnt) - FIFO_CW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_mem[r_wr_ptr] <= i_data_a;
        end
        if (i_push_b) begin
            r_mem[r_wr_ptr + FIFO_AW'(1)] <= i_data_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

### rtl/gaussian_blur_and_sharpen_3x3_top.sv
// 3x3 Gaussian blur and sharpen over a raster-order 8-bit grayscale stream. Takes one pixel
// per clock while o_ready is high. Each pixel is looked up in the two line stores (one
// block RAM port pair, read registered) in the cycle it is accepted and is filtered in the
// next cycle, so its results enter the output queue at the clock edge after the accepting
// edge, and o_valid comes from the registered queue count. A pixel at row r, column c with
// r, c >= 2 emits the interior result for centre (r-1, c-1): blurred = kernel
// {1,2,1;2,4,2;1,2,1} sum / 16, sharpened = kernel {0,-1,0;-1,5,-1;0,-1,0} sum when it lies
// in 1..254, else the centre pixel. A pixel on the frame border is also passed through as its
// own result tagged with its own row and column; when a pixel emits both, the interior beat
// comes first and last marks the final beat of the pixel. The output side moves one beat per
// clock while i_ready is high, so pixels that emit two beats (on the last row or last column,
// from row 2 and column 2 on) each add an extra output beat; an 8-entry output queue absorbs
// this and output stalls, and the input is ready whenever the queue still has room for the
// two pixels in flight. Writing image_width or image_height restarts the frame at row 0,
// column 0 and clears the window; write them only while the block is idle. Line-store
// contents are kept across a restart and need no clearing.
module gaussian_blur_and_sharpen_3x3_top
    import gbs_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // pixel input
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [PIX_W-1:0]      i_pixel,
    // result output
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [ROW_W-1:0]      o_out_row,
    output logic [COL_W-1:0]      o_out_col,
    output logic [PIX_W-1:0]      o_blurred,
    output logic [PIX_W-1:0]      o_sharpened,
    output logic                  o_last
);

    localparam int CW = $clog2(MAX_WIDTH);

    // Effective frame size, stored as size minus one after clamping.
    logic [CW-1:0]    r_wm1;
    logic [ROW_W-1:0] r_hm1;
    logic [CW-1:0]    n_wm1;
    logic [ROW_W-1:0] n_hm1;

    // Raster position of the next pixel.
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;

    // Filter stage: pixel accepted last cycle, line-store data arrives now.
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_px;
    logic [CW-1:0]    r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic             r_s1_fwd;
    logic [PIX_W-1:0] r_s1_fwd_top;
    logic [PIX_W-1:0] r_s1_fwd_mid;

    t_win             r_win;

    logic             accept;
    logic [PIX_W-1:0] mem_top;
    logic [PIX_W-1:0] mem_mid;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] k_blur;
    logic [PIX_W-1:0] k_sharp;
    logic             interior;
    logic             border;
    t_result          res_int;
    t_result          res_brd;
    t_result          push_a_data;
    logic             push_a;
    logic             push_b;
    t_result          q_data;
    logic [FIFO_CW-1:0] q_count;
    logic             pop;

    // Clamp the written frame size: zero acts as one, oversize acts as the maximum.
    always_comb begin
        logic [31:0] wraw;
        logic [31:0] hraw;
        wraw = 32'(i_cfg_data[WID_W-1:0]);
        hraw = 32'(i_cfg_data[HGT_W-1:0]);
        if (wraw == 32'd0) begin
            n_wm1 = '0;
        end else if (wraw > 32'(MAX_WIDTH)) begin
            n_wm1 = CW'(MAX_WIDTH - 1);
        end else begin
            n_wm1 = CW'(wraw - 32'd1);
        end
        if (hraw == 32'd0) begin
            n_hm1 = '0;
        end else if (hraw > 32'(MAX_HEIGHT)) begin
            n_hm1 = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            n_hm1 = ROW_W'(hraw - 32'd1);
        end
    end

    // Leave room in the queue for two beats from the filter stage and two from a new pixel.
    assign o_ready = (32'(q_count) + (r_s1_valid ? 32'd2 : 32'd0)) <= 32'(FIFO_DEPTH - 2);
    assign accept  = i_valid && o_ready;

    gbs_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_top  (mem_top),
        .o_rd_mid  (mem_mid),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_col),
        .i_wr_top  (mid),
        .i_wr_mid  (r_s1_px)
    );

    // A one-pixel-wide frame reads the column the filter stage is writing: bypass the RAM.
    assign top = r_s1_fwd ? r_s1_fwd_top : mem_top;
    assign mid = r_s1_fwd ? r_s1_fwd_mid : mem_mid;

    gbs_kernel u_kernel (
        .i_win       (r_win),
        .i_top       (top),
        .i_mid       (mid),
        .i_px        (r_s1_px),
        .o_blurred   (k_blur),
        .o_sharpened (k_sharp)
    );

    always_comb begin
        interior = (r_s1_row >= ROW_W'(2)) && (r_s1_col >= CW'(2));
        border = (r_s1_row == '0) || (r_s1_row == r_hm1)
              || (r_s1_col == '0) || (r_s1_col == r_wm1);

        res_int.row       = r_s1_row - ROW_W'(1);
        res_int.col       = COL_W'(r_s1_col - CW'(1));
        res_int.blurred   = k_blur;
        res_int.sharpened = k_sharp;
        res_int.last      = !border;

        res_brd.row       = r_s1_row;
        res_brd.col       = COL_W'(r_s1_col);
        res_brd.blurred   = r_s1_px;
        res_brd.sharpened = r_s1_px;
        res_brd.last      = 1'b1;

        // Interior beat goes first; the border beat follows it in the same push.
        push_a      = r_s1_valid && (interior || border);
        push_b      = r_s1_valid && interior && border;
        push_a_data = interior ? res_int : res_brd;
    end

    gbs_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (push_a),
        .i_data_a (push_a_data),
        .i_push_b (push_b),
        .i_data_b (res_brd),
        .i_pop    (pop),
        .o_valid  (o_valid),
        .o_data   (q_data),
        .o_count  (q_count)
    );

    assign pop         = o_valid && i_ready;
    assign o_out_row   = q_data.row;
    assign o_out_col   = q_data.col;
    assign o_blurred   = q_data.blurred;
    assign o_sharpened = q_data.sharpened;
    assign o_last      = q_data.last;

    // Control state: frame size, raster counters, window, filter-stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm1      <= CW'((MAX_WIDTH < 640) ? MAX_WIDTH - 1 : 640 - 1);
            r_hm1      <= ROW_W'(480 - 1);
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_win      <= '0;
        end else begin
            r_s1_valid <= accept;
            if (i_cfg_we && (i_cfg_idx == REG_IMAGE_WIDTH || i_cfg_idx == REG_IMAGE_HEIGHT)) begin
                if (i_cfg_idx == REG_IMAGE_WIDTH) begin
                    r_wm1 <= n_wm1;
                end else begin
                    r_hm1 <= n_hm1;
                end
                // restart the frame
                r_col <= '0;
                r_row <= '0;
                r_win <= '0;
            end else begin
                if (accept) begin
                    if (r_col == r_wm1) begin
                        r_col <= '0;
                        r_row <= (r_row == r_hm1) ? '0 : r_row + ROW_W'(1);
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                end
                if (r_s1_valid) begin
                    // advance the window by one column
                    r_win[0] <= r_win[3];
                    r_win[1] <= r_win[4];
                    r_win[2] <= r_win[5];
                    r_win[3] <= top;
                    r_win[4] <= mid;
                    r_win[5] <= r_s1_px;
                end
            end
        end
    end

    // Filter-stage payload; capture the bypass values when the RAM read misses this write.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px      <= i_pixel;
            r_s1_col     <= r_col;
            r_s1_row     <= r_row;
            r_s1_fwd     <= r_s1_valid && (r_s1_col == r_col);
            r_s1_fwd_top <= mid;
            r_s1_fwd_mid <= r_s1_px;
        end
    end

endmodule

### tb/sv/blur_sharpen_checker.sv
`timescale 1ns / 1ps

module blur_sharpen_checker
    import gbs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [ROW_W-1:0]      i_out_row,
    input  logic [COL_W-1:0]      i_out_col,
    input  logic [PIX_W-1:0]      i_blurred,
    input  logic [PIX_W-1:0]      i_sharpened,
    input  logic                  i_last,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_beats
);

    localparam int LINE_DEPTH = 2048;

    bit   [PIX_W-1:0] row_above     [LINE_DEPTH];
    bit   [PIX_W-1:0] row_two_above [LINE_DEPTH];
    logic [PIX_W-1:0] win [6];
    int               row_pos;
    int               col_pos;
    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    t_result          filtered_beats [$];
    t_result          want;

    // Work out the beats one pixel causes and advance the raster position.
    task filter_pixel(input logic [PIX_W-1:0] px);
        int               w;
        int               h;
        int               r;
        int               c;
        int               blur_sum;
        int               sharp_sum;
        bit               on_border;
        logic [PIX_W-1:0] top_px;
        logic [PIX_W-1:0] mid_px;
        t_result          beat;
        w = (width_reg == 0) ? 1 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : int'(width_reg));
        h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg));
        r = (row_pos >= h) ? 0 : row_pos;
        c = (col_pos >= w) ? 0 : col_pos;

        top_px = row_two_above[c];
        mid_px = row_above[c];
        row_two_above[c] = mid_px;
        row_above[c]     = px;

        on_border = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);

        if (r >= 2 && c >= 2) begin
            blur_sum = int'(win[0]) + 2 * int'(win[3]) + int'(top_px)
                     + 2 * int'(win[1]) + 4 * int'(win[4]) + 2 * int'(mid_px)
                     + int'(win[2]) + 2 * int'(win[5]) + int'(px);
            sharp_sum = 5 * int'(win[4]) - int'(win[3]) - int'(win[5])
                      - int'(win[1]) - int'(mid_px);
            beat.row       = ROW_W'(r - 1);
            beat.col       = COL_W'(c - 1);
            beat.blurred   = PIX_W'(blur_sum / 16);
            // out-of-range sharpen sums fall back to the centre pixel
            beat.sharpened = (sharp_sum >= 1 && sharp_sum <= 254) ? PIX_W'(sharp_sum) : win[4];
            beat.last      = !on_border;
            filtered_beats.push_back(beat);
        end

        if (on_border) begin
            beat.row       = ROW_W'(r);
            beat.col       = COL_W'(c);
            beat.blurred   = px;
            beat.sharpened = px;
            beat.last      = 1'b1;
            filtered_beats.push_back(beat);
        end

        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top_px;
        win[4] = mid_px;
        win[5] = px;

        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = WID_W'(640);
            height_reg = HGT_W'(480);
            row_pos    = 0;
            col_pos    = 0;
            o_errors   = 0;
            o_beats    = 0;
            for (int k = 0; k < 6; k++) win[k] = '0;
            filtered_beats.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_beats++;
                if (filtered_beats.size() == 0) begin
                    $error("result beat with nothing expected: row %0d col %0d",
                           i_out_row, i_out_col);
                    o_errors++;
                end else begin
                    want = filtered_beats.pop_front();
                    if (i_out_row !== want.row) begin
                        $error("out_row: expected %0d, actual %0d", want.row, i_out_row);
                        o_errors++;
                    end
                    if (i_out_col !== want.col) begin
                        $error("out_col: expected %0d, actual %0d", want.col, i_out_col);
                        o_errors++;
                    end
                    if (i_blurred !== want.blurred) begin
                        $error("blurred: expected %0d, actual %0d", want.blurred, i_blurred);
                        o_errors++;
                    end
                    if (i_sharpened !== want.sharpened) begin
                        $error("sharpened: expected %0d, actual %0d",
                               want.sharpened, i_sharpened);
                        o_errors++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, i_last);
                        o_errors++;
                    end
                end
            end

            // a register write restarts the frame; line stores are kept
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_IMAGE_WIDTH) begin
                    width_reg = i_cfg_data[WID_W-1:0];
                end else begin
                    height_reg = i_cfg_data[HGT_W-1:0];
                end
                row_pos = 0;
                col_pos = 0;
                for (int k = 0; k < 6; k++) win[k] = '0;
            end

            if (i_in_valid && i_in_ready) filter_pixel(i_pixel);
        end
        o_pending = filtered_beats.size();
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import gbs_pkg::*;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid    = 1'b0;
    logic                  o_ready;
    logic [PIX_W-1:0]      i_pixel    = '0;
    logic                  o_valid;
    logic                  i_ready    = 1'b0;
    logic [ROW_W-1:0]      o_out_row;
    logic [COL_W-1:0]      o_out_col;
    logic [PIX_W-1:0]      o_blurred;
    logic [PIX_W-1:0]      o_sharpened;
    logic                  o_last;

    int fail_count;
    int pending_beats;
    int checked_beats;

    // idle rates in percent, changed per phase
    int send_idle = 0;
    int recv_idle = 0;
    int pixels_sent = 0;
    int reg_writes = 0;

    logic [PIX_W-1:0] edge_grid [16];

    gaussian_blur_and_sharpen_3x3_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pixel     (i_pixel),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_blurred   (o_blurred),
        .o_sharpened (o_sharpened),
        .o_last      (o_last)
    );

    blur_sharpen_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_pixel     (i_pixel),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_out_row   (o_out_row),
        .i_out_col   (o_out_col),
        .i_blurred   (o_blurred),
        .i_sharpened (o_sharpened),
        .i_last      (o_last),
        .o_errors    (fail_count),
        .o_pending   (pending_beats),
        .o_beats     (checked_beats)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: redraw ready at every falling edge at the current idle rate.
    initial begin
        forever begin
            @(negedge i_clk);
            i_ready = ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Drop valid and hold until every expected beat is out, then idle for a
    // tail so that pixels with no result also clear the pipeline.
    task drain(input int tail);
        i_valid = 1'b0;
        while (pending_beats != 0) @(negedge i_clk);
        repeat (tail) @(negedge i_clk);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        reg_writes++;
    endtask

    // Reprogram the frame size while the block is idle. The width register
    // is 12 bits wide, so the top data bit is junk and must be ignored.
    task set_frame(input int w_cfg, input int h_cfg);
        logic [CFG_DATA_W-1:0] wdata;
        drain(6);
        wdata = CFG_DATA_W'(w_cfg[WID_W-1:0]);
        wdata[CFG_DATA_W-1] = $urandom_range(0, 1);
        if ($urandom_range(0, 1)) begin
            write_reg(REG_IMAGE_WIDTH, wdata);
            write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_cfg));
        end else begin
            write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_cfg));
            write_reg(REG_IMAGE_WIDTH, wdata);
        end
    endtask

    // Send one beat; called and returning at a falling edge.
    task push_pixel(input logic [PIX_W-1:0] px);
        // now and then hold off mid-frame until the output side is empty
        if ($urandom_range(0, 99) == 0) drain(0);
        while ($urandom_range(0, 99) < send_idle) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_pixel = px;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    // Pixel styles: full random, black/white only, smooth around a base
    // (keeps sharpen sums near the centre value), random with saturated sprinkles.
    function automatic logic [PIX_W-1:0] make_pixel(input int style, input int base);
        int v;
        case (style)
            0: v = $urandom_range(0, 255);
            1: v = $urandom_range(0, 1) ? 255 : 0;
            2: begin
                v = base + $urandom_range(0, 16) - 8;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: v = 0;
                    1: v = 255;
                    default: v = $urandom_range(0, 255);
                endcase
            end
        endcase
        return PIX_W'(v);
    endfunction

    // Random frame sizes, mostly small, fed whole frames with a partial
    // frame now and then so the next restart lands mid-frame.
    task run_random(input int n_items);
        int done;
        int w_cfg;
        int h_cfg;
        int w_eff;
        int h_eff;
        int count;
        int style;
        int base;
        done = 0;
        while (done < n_items) begin
            case ($urandom_range(0, 19))
                0: begin
                    w_cfg = 0;
                    h_cfg = $urandom_range(1, 6);
                end
                1: begin
                    w_cfg = $urandom_range(1, 6);
                    h_cfg = 0;
                end
                2, 3: begin
                    w_cfg = $urandom_range(13, 48);
                    h_cfg = $urandom_range(3, 4);
                end
                default: begin
                    w_cfg = $urandom_range(1, 12);
                    h_cfg = $urandom_range(1, 8);
                end
            endcase
            w_eff = (w_cfg == 0) ? 1 : w_cfg;
            h_eff = (h_cfg == 0) ? 1 : h_cfg;
            count = w_eff * h_eff * $urandom_range(1, 2);
            if ($urandom_range(0, 2) == 0) count += $urandom_range(1, w_eff * h_eff);
            // stop at the phase budget, cutting the last frame short
            if (count > n_items - done) count = n_items - done;
            style = $urandom_range(0, 3);
            base  = $urandom_range(0, 255);
            set_frame(w_cfg, h_cfg);
            repeat (count) push_pixel(make_pixel(style, base));
            done += count;
        end
    endtask

    initial begin
        // 4x4 frame whose four interior centres give sharpen sums of exactly
        // 0, 254, 1 and 255: both clamp edges from each side
        edge_grid = '{8'd0,   8'd50,  8'd40,  8'd255,
                      8'd50,  8'd60,  8'd100, 8'd46,
                      8'd255, 8'd100, 8'd100, 8'd20,
                      8'd0,   8'd84,  8'd25,  8'd255};

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Phase 1: sender mostly busy, receiver mostly stalled
        send_idle = 19;
        recv_idle = 87;

        // a couple of beats at the reset frame size
        push_pixel(8'h00);
        push_pixel(8'hFF);

        set_frame(4, 4);
        for (int k = 0; k < 16; k++) begin
            push_pixel(edge_grid[k]);
            // one forced pause mid-frame with everything drained
            if (k == 7) drain(0);
        end
        // wrap into the next frame
        push_pixel(8'hA5);
        push_pixel(8'h5A);
        push_pixel(8'h81);

        run_random(250);

        // Phase 2: sender mostly idle, receiver mostly ready
        send_idle = 87;
        recv_idle = 19;
        run_random(250);

        // Phase 3: no idling on either side
        send_idle = 0;
        recv_idle = 0;
        run_random(200);

        set_frame(1, 1);
        repeat (5) push_pixel(make_pixel(0, 0));

        // widest frame (clamped from 4095), three rows: a stretch of the first row
        set_frame(4095, 3);
        repeat (40) push_pixel(make_pixel(0, 0));

        // tallest frame (clamped from 8191), one pixel wide
        set_frame(0, 8191);
        repeat (40) push_pixel(make_pixel(3, 0));

        // in-range maximums, a short stretch of the first row
        set_frame(2048, 4096);
        repeat (40) push_pixel(make_pixel(0, 0));

        drain(10);

        $display("Run covered %0d pixels, %0d result beats and %0d register writes,",
                 pixels_sent, checked_beats, reg_writes);
        $display("frame sizes from 1x1 to 2048 wide and 4096 tall, clamped values included.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Timeout with %0d beats still expected", pending_beats);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
